/* hdl/chrt_pkg.sv */
// ----------------------------------------------------------------------------
// chrt_pkg
// Shared sizes, codes and controller/datapath signal groups for the chained
// hash record table.
// ----------------------------------------------------------------------------
package chrt_pkg;

  localparam int BUCKETS      = 16;
  localparam int POOL_ENTRIES = 64;

  localparam int LINK_W = $clog2(POOL_ENTRIES + 1);
  localparam int IDX_W  = $clog2(POOL_ENTRIES);
  localparam int BKT_W  = $clog2(BUCKETS);
  localparam int CNT_W  = 5;
  localparam int KEY_W  = 16;
  localparam int DATA_W = 32;
  localparam int SUM_W  = 34;
  localparam int MAG_W  = SUM_W - 1;
  localparam int STEP_W = $clog2(POOL_ENTRIES) + 1;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_ENTRIES);
  localparam logic [CNT_W-1:0]  BUCKET_COUNT_RESET = CNT_W'(10);
  localparam logic [CNT_W-1:0]  BUCKET_MAX = CNT_W'(BUCKETS);

  // reciprocals of 3 for a 17-bit and an 18-bit dividend
  localparam logic [16:0] DIV3_HI_MUL = 17'd87382;
  localparam logic [17:0] DIV3_LO_MUL = 18'd174763;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SEARCH = 3'd1,
    OP_REMOVE = 3'd2,
    OP_MEAN   = 3'd3,
    OP_MAX    = 3'd4,
    OP_MIN    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic    capture;
    logic    hash_go;
    logic    head_load;
    logic    adv;
    logic    hit_save;
    logic    add_rd;
    logic    add_wr;
    logic    rm_unlink;
    logic    rm_free;
    logic    rep_go;
    logic    mean_fin;
    logic    res_set;
    status_t res_status;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       div_busy;
    logic       full;
    logic       cur_nil;
    logic       hit;
    logic       chain_end;
    logic       out_free;
  } stat_t;

endpackage

/* hdl/chrt_in_if.sv */
// ----------------------------------------------------------------------------
// chrt_in_if
// Request channel: operation, key and three readings.
// ----------------------------------------------------------------------------
interface chrt_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic [15:0]        key;
  logic signed [31:0] temperature;
  logic signed [31:0] vibration;
  logic signed [31:0] pressure;

  modport source (output valid, op, key, temperature, vibration, pressure, input ready);
  modport sink (input valid, op, key, temperature, vibration, pressure, output ready);
endinterface

/* hdl/chrt_out_if.sv */
// ----------------------------------------------------------------------------
// chrt_out_if
// Response channel: status and report value.
// ----------------------------------------------------------------------------
interface chrt_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] value;

  modport source (output valid, status, value, input ready);
  modport sink (input valid, status, value, output ready);
endinterface

/* hdl/chrt_div.sv */
// ----------------------------------------------------------------------------
// chrt_div
// Restoring remainder unit, one dividend bit per cycle, small divisor.
// ----------------------------------------------------------------------------
module chrt_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [chrt_pkg::SUM_W-1:0]    dividend,
  input  logic [chrt_pkg::CNT_W-1:0]    divisor,
  output logic                          busy,
  output logic [chrt_pkg::CNT_W-1:0]    rem
);
  import chrt_pkg::*;

  localparam int CYC_W = $clog2(SUM_W);

  logic [CYC_W-1:0] cnt;
  logic [CNT_W-1:0] dvs;
  logic [CNT_W:0]   trial;
  logic             fits;
  logic [SUM_W-1:0] quot;

  assign trial = {rem, quot[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CYC_W'(1);
      if (cnt == CYC_W'(SUM_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      rem  <= fits ? CNT_W'(trial - {1'b0, dvs}) : trial[CNT_W-1:0];
      quot <= {quot[SUM_W-2:0], fits};
    end
  end
endmodule

/* hdl/chrt_dp.sv */
// ----------------------------------------------------------------------------
// chrt_dp
// Datapath: bucket heads, link and record memories, free list, chain walk
// registers, divider and result registers.
// ----------------------------------------------------------------------------
module chrt_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [4:0]           cfg_wdata,
  input  chrt_pkg::cmd_t       cmd,
  output chrt_pkg::stat_t      stat,
  chrt_in_if.sink              in_ch,
  chrt_out_if.source           out_ch
);
  import chrt_pkg::*;

  logic [CNT_W-1:0]  bucket_count;
  logic [2:0]        op_r;
  logic [KEY_W-1:0]  key_r;
  logic [DATA_W-1:0] t_r, v_r, p_r;

  logic [LINK_W-1:0] bucket_heads [BUCKETS];
  logic [LINK_W-1:0] free_head;
  logic [LINK_W-1:0] cur, prev, hit_next;
  logic [STEP_W-1:0] steps;

  logic [LINK_W-1:0] link_mem [POOL_ENTRIES];
  logic [POOL_ENTRIES-1:0] link_vld;
  logic [KEY_W-1:0]  key_mem [POOL_ENTRIES];
  logic [DATA_W-1:0] t_mem [POOL_ENTRIES];
  logic [DATA_W-1:0] v_mem [POOL_ENTRIES];
  logic [DATA_W-1:0] p_mem [POOL_ENTRIES];

  logic [LINK_W-1:0] link_q;
  logic              link_vld_q;
  logic [IDX_W-1:0]  link_addr_q;
  logic [LINK_W-1:0] link_rd;
  logic [KEY_W-1:0]  key_q;
  logic signed [DATA_W-1:0] t_q, v_q, p_q;

  logic              link_we;
  logic [IDX_W-1:0]  link_waddr;
  logic [LINK_W-1:0] link_wdata;
  logic [IDX_W-1:0]  link_raddr;

  logic [CNT_W-1:0]  divisor;
  logic              div_start;
  logic [SUM_W-1:0]  div_in;
  logic              div_busy;
  logic [CNT_W-1:0]  rem;
  logic [BKT_W-1:0]  bucket;

  logic signed [SUM_W-1:0] sum;
  logic              neg_r;
  logic signed [DATA_W-1:0] max_v, min_v;

  logic [MAG_W-1:0]  mag_r;
  logic              mean_busy;
  logic [15:0]       q_hi, q_hi_r, q_lo;
  logic [1:0]        r_hi, r_hi_r;
  logic [DATA_W-1:0] mean_mag;

  status_t           res_status;
  logic [DATA_W-1:0] res_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BUCKET_COUNT_RESET;
    end else if (cfg_we) begin
      bucket_count <= cfg_wdata;
    end
  end

  always_comb begin
    if (bucket_count == '0) begin
      divisor = CNT_W'(1);
    end else if (bucket_count > BUCKET_MAX) begin
      divisor = BUCKET_MAX;
    end else begin
      divisor = bucket_count;
    end
  end

  assign bucket = rem[BKT_W-1:0];
  assign sum = SUM_W'(signed'(t_q)) + SUM_W'(signed'(v_q)) + SUM_W'(signed'(p_q));
  assign div_start = cmd.hash_go;
  assign div_in = SUM_W'(key_r);

  chrt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_in),
    .divisor  (divisor),
    .busy     (div_busy),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_ch.op;
      key_r <= in_ch.key;
      t_r   <= in_ch.temperature;
      v_r   <= in_ch.vibration;
      p_r   <= in_ch.pressure;
    end
  end

  // link memory write port
  always_comb begin
    link_we    = 1'b0;
    link_waddr = free_head[IDX_W-1:0];
    link_wdata = bucket_heads[bucket];
    if (cmd.add_wr) begin
      link_we = 1'b1;
    end else if (cmd.rm_unlink && prev != NIL) begin
      link_we    = 1'b1;
      link_waddr = prev[IDX_W-1:0];
      link_wdata = hit_next;
    end else if (cmd.rm_free) begin
      link_we    = 1'b1;
      link_waddr = cur[IDX_W-1:0];
      link_wdata = free_head;
    end
  end

  assign link_raddr = cmd.add_rd ? free_head[IDX_W-1:0] : cur[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_q <= link_mem[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_vld <= '0;
    end else if (link_we) begin
      link_vld[link_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    link_vld_q  <= link_vld[link_raddr];
    link_addr_q <= link_raddr;
  end

  assign link_rd = link_vld_q ? link_q : LINK_W'(link_addr_q) + LINK_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.add_wr) begin
      key_mem[free_head[IDX_W-1:0]] <= key_r;
    end
    key_q <= key_mem[cur[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.add_wr) begin
      t_mem[free_head[IDX_W-1:0]] <= t_r;
    end
    t_q <= t_mem[cur[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.add_wr) begin
      v_mem[free_head[IDX_W-1:0]] <= v_r;
    end
    v_q <= v_mem[cur[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.add_wr) begin
      p_mem[free_head[IDX_W-1:0]] <= p_r;
    end
    p_q <= p_mem[cur[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BUCKETS; i++) begin
        bucket_heads[i] <= NIL;
      end
      free_head <= '0;
    end else begin
      if (cmd.add_wr) begin
        bucket_heads[bucket] <= free_head;
        free_head            <= link_rd;
      end
      if (cmd.rm_unlink && prev == NIL) begin
        bucket_heads[bucket] <= hit_next;
      end
      if (cmd.rm_free) begin
        free_head <= cur;
      end
    end
  end

  // chain walk
  always_ff @(posedge clk) begin
    if (cmd.head_load) begin
      cur   <= bucket_heads[bucket];
      prev  <= NIL;
      steps <= '0;
    end else if (cmd.adv) begin
      prev  <= cur;
      cur   <= link_rd;
      steps <= steps + STEP_W'(1);
    end
    if (cmd.hit_save) begin
      hit_next <= link_rd;
    end
  end

  always_comb begin
    max_v = t_q;
    if (v_q > max_v) max_v = v_q;
    if (p_q > max_v) max_v = p_q;
    min_v = t_q;
    if (v_q < min_v) min_v = v_q;
    if (p_q < min_v) min_v = p_q;
  end

  // divide the sum magnitude by three in two 16-bit digits
  always_comb begin
    q_hi = 16'((34'(mag_r[MAG_W-1:16]) * 34'(DIV3_HI_MUL)) >> 18);
    r_hi = 2'(mag_r[MAG_W-1:16] - ({1'b0, q_hi} + {q_hi, 1'b0}));
    q_lo = 16'((35'({r_hi_r, mag_r[15:0]}) * 35'(DIV3_LO_MUL)) >> 19);
  end

  assign mean_mag = {q_hi_r, q_lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_busy <= 1'b0;
    end else begin
      mean_busy <= cmd.rep_go && op_r == OP_MEAN;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rep_go) begin
      mag_r <= sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
      neg_r <= sum[SUM_W-1];
    end
    if (mean_busy) begin
      q_hi_r <= q_hi;
      r_hi_r <= r_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status <= cmd.res_status;
      res_value  <= '0;
    end else if (cmd.rep_go) begin
      res_status <= ST_OK;
      res_value  <= (op_r == OP_MAX) ? max_v : min_v;
    end else if (cmd.mean_fin) begin
      res_value <= neg_r ? -mean_mag : mean_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch.status <= res_status;
      out_ch.value  <= res_value;
    end
  end

  assign stat.op        = op_r;
  assign stat.div_busy  = div_busy || mean_busy;
  assign stat.full      = free_head == NIL;
  assign stat.cur_nil   = cur == NIL;
  assign stat.hit       = key_q == key_r;
  assign stat.chain_end = link_rd == NIL || steps == STEP_W'(POOL_ENTRIES - 1);
  assign stat.out_free  = !out_ch.valid || out_ch.ready;
endmodule

/* hdl/chrt_ctrl.sv */
// ----------------------------------------------------------------------------
// chrt_ctrl
// Controller: sequences hashing, chain walk, list updates and reports.
// ----------------------------------------------------------------------------
module chrt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  chrt_pkg::stat_t  stat,
  output chrt_pkg::cmd_t   cmd
);
  import chrt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_HASH, S_HEAD, S_RD, S_CHK, S_ADD_RD, S_ADD_WR,
    S_RM_UNL, S_RM_FREE, S_REP, S_MEAN, S_FIN
  } state_t;

  state_t state, state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_START;
        end
      end
      S_START: begin
        if (stat.op > OP_MIN) begin
          cmd.res_set = 1'b1;
          cmd.res_status = ST_OK;
          state_next = S_FIN;
        end else if (stat.op == OP_ADD && stat.full) begin
          cmd.res_set = 1'b1;
          cmd.res_status = ST_FULL;
          state_next = S_FIN;
        end else begin
          cmd.hash_go = 1'b1;
          state_next  = S_HASH;
        end
      end
      S_HASH: begin
        if (!stat.div_busy) begin
          state_next = (stat.op == OP_ADD) ? S_ADD_RD : S_HEAD;
        end
      end
      S_HEAD: begin
        cmd.head_load = 1'b1;
        state_next    = S_RD;
      end
      S_RD: begin
        if (stat.cur_nil) begin
          cmd.res_set = 1'b1;
          cmd.res_status = ST_MISS;
          state_next = S_FIN;
        end else begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.hit) begin
          cmd.hit_save = 1'b1;
          if (stat.op == OP_SEARCH) begin
            cmd.res_set = 1'b1;
            cmd.res_status = ST_OK;
            state_next = S_FIN;
          end else if (stat.op == OP_REMOVE) begin
            state_next = S_RM_UNL;
          end else begin
            state_next = S_REP;
          end
        end else if (stat.chain_end) begin
          cmd.res_set = 1'b1;
          cmd.res_status = ST_MISS;
          state_next = S_FIN;
        end else begin
          cmd.adv    = 1'b1;
          state_next = S_RD;
        end
      end
      S_ADD_RD: begin
        cmd.add_rd = 1'b1;
        state_next = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd.add_wr = 1'b1;
        cmd.res_set = 1'b1;
        cmd.res_status = ST_OK;
        state_next = S_FIN;
      end
      S_RM_UNL: begin
        cmd.rm_unlink = 1'b1;
        state_next    = S_RM_FREE;
      end
      S_RM_FREE: begin
        cmd.rm_free = 1'b1;
        cmd.res_set = 1'b1;
        cmd.res_status = ST_OK;
        state_next = S_FIN;
      end
      S_REP: begin
        cmd.rep_go = 1'b1;
        state_next = (stat.op == OP_MEAN) ? S_MEAN : S_FIN;
      end
      S_MEAN: begin
        if (!stat.div_busy) begin
          cmd.mean_fin = 1'b1;
          state_next   = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

/* hdl/chained_hash_record_table.sv */
// ----------------------------------------------------------------------------
// chained_hash_record_table
// Keyed record table with separate chaining over a fixed entry pool.
//
//   channel   dir  handshake     payload
//   in_ch     in   valid/ready   op, key, temperature, vibration, pressure
//   out_ch    out  valid/ready   status, value
//   cfg       in   cfg_we        cfg_wdata (bucket count)
//
// One transaction at a time. Hashing runs in the serial remainder unit;
// each chain entry visited takes a registered memory read and a compare.
// Max and min reports add a report step, a mean also a divide-by-three
// step, and a remove an unlink step and a free step.
// Reset is synchronous; link memory reads back its free-list order from
// per-entry valid bits, so no clearing pass is needed.
// A result waits in the output register while a stalled sink holds it.
// ----------------------------------------------------------------------------
module chained_hash_record_table (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  chrt_in_if.sink    in_ch,
  chrt_out_if.source out_ch
);
  import chrt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  chrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  chrt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );
endmodule

/* tb/sv/record_table_checker.sv */
// ----------------------------------------------------------------------------
// record_table_checker
// Watches the request, response and bucket-count ports of the chained hash
// record table. It keeps its own copy of the chains, free list and stored
// readings, queues the status and value due for each accepted request, and
// compares every accepted response against the oldest queued one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module record_table_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  chrt_in_if         in_ch,
  chrt_out_if        out_ch,
  output int         errors,
  output int         outstanding
);
  import chrt_pkg::*;

  typedef struct {
    status_t            status;
    logic signed [31:0] value;
  } answer_t;

  answer_t            answers_due[$];
  logic [4:0]         bucket_reg;
  logic [6:0]         head_of[BUCKETS];
  logic [6:0]         link_of[POOL_ENTRIES];
  logic [6:0]         free_ptr;
  logic [15:0]        key_of[POOL_ENTRIES];
  logic signed [31:0] temp_of[POOL_ENTRIES];
  logic signed [31:0] vib_of[POOL_ENTRIES];
  logic signed [31:0] pres_of[POOL_ENTRIES];

  assign outstanding = answers_due.size();

  function automatic int bucket_for(logic [15:0] k);
    int n;
    n = bucket_reg;
    if (n == 0) n = 1;
    if (n > BUCKETS) n = BUCKETS;
    return k % n;
  endfunction

  function automatic logic [6:0] locate(logic [15:0] k, output logic [6:0] prv);
    logic [6:0] cur;
    logic [6:0] back;
    int steps;
    cur = head_of[bucket_for(k)];
    back = NIL;
    steps = 0;
    while (cur < POOL_ENTRIES && steps < POOL_ENTRIES) begin
      if (key_of[cur] == k) begin
        prv = back;
        return cur;
      end
      back = cur;
      cur = link_of[cur];
      steps++;
    end
    prv = NIL;
    return NIL;
  endfunction

  function automatic answer_t apply_request(logic [2:0] op, logic [15:0] k,
                                            logic signed [31:0] t,
                                            logic signed [31:0] v,
                                            logic signed [31:0] p);
    answer_t a;
    logic [6:0] hit;
    logic [6:0] prv;
    logic [6:0] e;
    int b;
    longint s;
    longint r;
    a.status = ST_OK;
    a.value = '0;
    case (op)
      OP_ADD: begin
        if (free_ptr >= POOL_ENTRIES) begin
          a.status = ST_FULL;
        end else begin
          e = free_ptr;
          b = bucket_for(k);
          free_ptr = link_of[e];
          key_of[e] = k;
          temp_of[e] = t;
          vib_of[e] = v;
          pres_of[e] = p;
          link_of[e] = head_of[b];
          head_of[b] = e;
        end
      end
      OP_SEARCH: begin
        hit = locate(k, prv);
        if (hit >= POOL_ENTRIES) a.status = ST_MISS;
      end
      OP_REMOVE: begin
        hit = locate(k, prv);
        if (hit >= POOL_ENTRIES) begin
          a.status = ST_MISS;
        end else begin
          if (prv >= POOL_ENTRIES) head_of[bucket_for(k)] = link_of[hit];
          else link_of[prv] = link_of[hit];
          link_of[hit] = free_ptr;
          free_ptr = hit;
        end
      end
      OP_MEAN, OP_MAX, OP_MIN: begin
        hit = locate(k, prv);
        if (hit >= POOL_ENTRIES) begin
          a.status = ST_MISS;
        end else begin
          if (op == OP_MEAN) begin
            s = longint'(temp_of[hit]) + longint'(vib_of[hit]) + longint'(pres_of[hit]);
            r = s / 3;
          end else if (op == OP_MAX) begin
            r = temp_of[hit];
            if (vib_of[hit] > r) r = vib_of[hit];
            if (pres_of[hit] > r) r = pres_of[hit];
          end else begin
            r = temp_of[hit];
            if (vib_of[hit] < r) r = vib_of[hit];
            if (pres_of[hit] < r) r = pres_of[hit];
          end
          a.value = r[31:0];
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      errors <= 0;
      answers_due.delete();
      bucket_reg = BUCKET_COUNT_RESET;
      free_ptr = 0;
      for (int i = 0; i < BUCKETS; i++) head_of[i] = NIL;
      for (int i = 0; i < POOL_ENTRIES; i++) link_of[i] = 7'(i + 1);
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (answers_due.size() == 0) begin
          $display("%0t: response with none due: status %0d value %0d",
                   $time, out_ch.status, out_ch.value);
          errors <= errors + 1;
        end else begin
          want = answers_due.pop_front();
          if (out_ch.status !== want.status || out_ch.value !== want.value) begin
            $display("%0t: mismatch expected status %0d value %0d, actual status %0d value %0d",
                     $time, want.status, want.value, out_ch.status, out_ch.value);
            errors <= errors + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        answers_due.push_back(apply_request(in_ch.op, in_ch.key, in_ch.temperature,
                                            in_ch.vibration, in_ch.pressure));
      if (cfg_we) bucket_reg = cfg_wdata;
    end
  end

endmodule

/* tb/sv/chained_hash_record_table_test.sv */
// ----------------------------------------------------------------------------
// chained_hash_record_table_test
// Drives requests in random bursts against a stalling response sink, runs a
// directed opening and then random phases over several bucket counts, and
// reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chained_hash_record_table_test;
  import chrt_pkg::*;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int         SETTLE    = 250;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [4:0] cfg_wdata;
  int         errors;
  int         outstanding;
  int         burst_left;
  logic [15:0] phase_keys[10];

  chrt_in_if  in_ch ();
  chrt_out_if out_ch ();

  chained_hash_record_table DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  record_table_checker scoreboard (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch), .errors(errors), .outstanding(outstanding)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

  // receiver stall pattern: duty out of period, reshuffled now and then
  initial begin
    int period;
    int duty;
    int tick;
    out_ch.ready = 1'b0;
    period = 1;
    duty = 1;
    tick = 0;
    forever begin
      @(negedge clk);
      if (tick % 300 == 0) begin
        period = $urandom_range(1, 8);
        duty = ($urandom_range(0, 2) == 0) ? period : $urandom_range(1, period);
      end
      out_ch.ready = (tick % period) < duty;
      tick++;
    end
  end

  function automatic logic signed [31:0] pick_reading();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(logic [2:0] op, logic [15:0] k, logic signed [31:0] t,
                      logic signed [31:0] v, logic signed [31:0] p);
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    in_ch.valid = 1'b1;
    in_ch.op = op;
    in_ch.key = k;
    in_ch.temperature = t;
    in_ch.vibration = v;
    in_ch.pressure = p;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic send_rand(logic [2:0] op, logic [15:0] k);
    send(op, k, pick_reading(), pick_reading(), pick_reading());
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_buckets(logic [4:0] n);
    drain();
    cfg_we = 1'b1;
    cfg_wdata = n;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_wdata = 5'($urandom);
  endtask

  task automatic random_phase(int count);
    int r;
    logic [2:0] op;
    logic [15:0] k;
    for (int i = 0; i < 10; i++)
      phase_keys[i] = (i < 6) ? 16'($urandom_range(0, 40)) : 16'($urandom);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 38) op = OP_ADD;
      else if (r < 52) op = OP_SEARCH;
      else if (r < 70) op = OP_REMOVE;
      else if (r < 78) op = OP_MEAN;
      else if (r < 86) op = OP_MAX;
      else if (r < 94) op = OP_MIN;
      else op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
      k = ($urandom_range(0, 9) < 8) ? phase_keys[$urandom_range(0, 9)] : 16'($urandom);
      send_rand(op, k);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    burst_left = 0;
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.key = '0;
    in_ch.temperature = '0;
    in_ch.vibration = '0;
    in_ch.pressure = '0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    send(OP_ADD, 16'h0000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send(OP_ADD, 16'hFFFF, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    send(OP_MEAN, 16'h0000, 0, 0, 0);
    send(OP_MEAN, 16'hFFFF, 0, 0, 0);
    send(OP_ADD, 16'd7, -32'sd5, 32'sd1, 32'sd2);
    send(OP_MEAN, 16'd7, 0, 0, 0);
    send(OP_MAX, 16'd7, 0, 0, 0);
    send(OP_MIN, 16'd7, 0, 0, 0);
    send(OP_ADD, 16'd7, 32'sd9, 32'sd3, -32'sd4);
    send(OP_MAX, 16'd7, 0, 0, 0);
    send(OP_ADD, 16'd17, 32'sd1, 32'sd2, 32'sd3);
    send(OP_SEARCH, 16'd17, 0, 0, 0);
    send(OP_REMOVE, 16'd7, 0, 0, 0);
    send(OP_MIN, 16'd7, 0, 0, 0);
    send(OP_REMOVE, 16'd7, 0, 0, 0);
    send(OP_SEARCH, 16'd7, 0, 0, 0);
    send(OP_REMOVE, 16'd7, 0, 0, 0);
    send(OP_MEAN, 16'd27, 0, 0, 0);
    send(OP_SPARE6, 16'd17, 1, 1, 1);
    send(OP_SPARE7, 16'hFFFF, -1, -1, -1);
    send(OP_SEARCH, 16'd17, 0, 0, 0);

    set_buckets(5'd0);
    send_rand(OP_SEARCH, 16'd17);
    for (int i = 0; i < 66; i++) send_rand(OP_ADD, 16'($urandom));
    send_rand(OP_ADD, 16'd3);
    random_phase(60);
    set_buckets(5'd31);
    random_phase(120);
    set_buckets(5'd16);
    random_phase(120);
    set_buckets(5'd1);
    random_phase(120);
    set_buckets(5'd10);
    random_phase(120);
    set_buckets(5'd3);
    random_phase(120);
    set_buckets(5'($urandom_range(0, 31)));
    random_phase(100);
    set_buckets(5'd17);
    random_phase(100);

    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/chrt_pkg.sv
hdl/chrt_in_if.sv
hdl/chrt_out_if.sv
hdl/chrt_div.sv
hdl/chrt_dp.sv
hdl/chrt_ctrl.sv
hdl/chained_hash_record_table.sv
tb/sv/record_table_checker.sv
tb/sv/chained_hash_record_table_test.sv
